>>> design/ibd_pkg.sv
package ibd_pkg;

  localparam int unsigned LIM_W  = 24;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned DUTY_W = 10;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 8'd10;
  localparam logic [CFG_W-1:0] BRIGHT_RST  = 8'd255;

  localparam logic [LIM_W-1:0] MS_PER_MIN     = 24'd60000;
  localparam logic [LIM_W-1:0] DIM_MIN_MS     = 24'd30000;
  localparam logic [LIM_W-1:0] DIM_BACKOFF_MS = 24'd1000;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_BRIGHT  = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ACT  = 2'd1,
    OP_OFF  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    LVL_FULL = 2'd0,
    LVL_DIM  = 2'd1,
    LVL_OFF  = 2'd2
  } level_t;

  function automatic logic [LIM_W-1:0] off_lim_f(logic [CFG_W-1:0] minutes);
    return LIM_W'(minutes) * MS_PER_MIN;
  endfunction

  function automatic logic [LIM_W-1:0] dim_lim_f(logic [LIM_W-1:0] off_lim);
    logic [LIM_W-1:0] d;
    d = off_lim >> 1;
    if (d < DIM_MIN_MS) begin
      d = DIM_MIN_MS;
    end
    if (d >= off_lim) begin
      d = (off_lim > DIM_BACKOFF_MS) ? (off_lim - DIM_BACKOFF_MS) : '0;
    end
    return d;
  endfunction

endpackage

>>> design/idle_backlight_dimmer_top.sv
// Idle backlight dimmer. Each input beat is a tick, a user activity or a
// forced-off request (in_tuser) with the current millisecond time (in_tdata);
// each one yields exactly one result beat with the backlight level, the PWM
// duty, a lit flag and the auto-dimming flag. The block takes one beat per
// clock cycle while out_tready does not stall the result register; a beat is
// held in the input register, then in the result register, and stalls on
// out_tready without loss. The idle limits and duty tables follow the
// configuration registers (timeout in minutes at address 0, brightness at
// address 4), which should be written only while no beat is in flight.
module idle_backlight_dimmer_top
  import ibd_pkg::*;
#(
  parameter int unsigned PWM_MAX       = 1023,
  parameter int unsigned DIM_FLOOR     = 40,
  parameter int unsigned WAKE_LATCH_MS = 2000
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] now_ms
  input  logic [1:0]  in_tuser,   // [1:0] op

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] level, [11:2] duty, [12] lit, [13] auto_on

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [TIME_W-1:0] WAKE_MS = TIME_W'(WAKE_LATCH_MS);
  localparam logic [LIM_W-1:0]  OFF_RST = off_lim_f(TIMEOUT_RST);
  localparam logic [LIM_W-1:0]  DIM_RST = dim_lim_f(OFF_RST);

  function automatic int unsigned full_c(int unsigned b);
    int unsigned bb;
    bb = (b == 0) ? 1 : b;
    if (bb >= 255) begin
      return PWM_MAX;
    end
    return (bb * PWM_MAX) / 255;
  endfunction

  function automatic int unsigned dim_c(int unsigned f);
    int unsigned d;
    d = f / 6;
    if (d < DIM_FLOOR && f > DIM_FLOOR) begin
      d = DIM_FLOOR;
    end
    if (d >= f) begin
      d = (f > 1) ? (f / 2) : 1;
    end
    return d;
  endfunction

  logic [DUTY_W-1:0] full_tab [256];
  logic [DUTY_W-1:0] dim_tab  [256];

  for (genvar g = 0; g < 256; g++) begin : g_duty_tab
    localparam int unsigned FULL_V = full_c(g);
    localparam int unsigned DIM_V  = dim_c(FULL_V);
    assign full_tab[g] = FULL_V[DUTY_W-1:0];
    assign dim_tab[g]  = DIM_V[DUTY_W-1:0];
  end

  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic [15:0]       out_data_nxt;

  level_t            level_r, level_nxt;
  logic [TIME_W-1:0] last_act_r, last_act_nxt;
  logic [TIME_W-1:0] wake_r, wake_nxt;
  logic [CFG_W-1:0]  timeout_r, timeout_nxt;
  logic [CFG_W-1:0]  bright_r, bright_nxt;
  logic [LIM_W-1:0]  off_lim_r, off_lim_nxt;
  logic [LIM_W-1:0]  dim_lim_r, dim_lim_nxt;

  logic              adv;
  logic              in_fire;
  logic              s2_fire;
  logic              cfg_we;
  logic [TIME_W-1:0] idle;
  logic [DUTY_W-1:0] duty;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || adv;
  assign in_fire    = in_tvalid && in_tready;
  assign s2_fire    = s1_valid_r && adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_BRIGHT) ? {24'd0, bright_r} : {24'd0, timeout_r};

  always_comb begin
    timeout_nxt = timeout_r;
    bright_nxt  = bright_r;
    if (cfg_we && cfg_paddr[2] == REG_TIMEOUT) begin
      timeout_nxt = cfg_pwdata[CFG_W-1:0];
    end
    if (cfg_we && cfg_paddr[2] == REG_BRIGHT) begin
      bright_nxt = cfg_pwdata[CFG_W-1:0];
    end
    off_lim_nxt = off_lim_f(timeout_nxt);
    dim_lim_nxt = dim_lim_f(off_lim_nxt);
  end

  always_comb begin
    level_nxt    = level_r;
    last_act_nxt = last_act_r;
    wake_nxt     = wake_r;
    idle         = s1_now_r - last_act_r;
    unique case (s1_op_r)
      OP_TICK: begin
        if (timeout_r == '0 || s1_now_r < wake_r) begin
          level_nxt = LVL_FULL;
        end else if (idle >= TIME_W'(off_lim_r)) begin
          level_nxt = LVL_OFF;
        end else if (idle >= TIME_W'(dim_lim_r)) begin
          level_nxt = LVL_DIM;
        end else begin
          level_nxt = LVL_FULL;
        end
      end
      OP_ACT: begin
        if (level_r != LVL_FULL) begin
          wake_nxt = s1_now_r + WAKE_MS;
        end
        last_act_nxt = s1_now_r;
        level_nxt    = LVL_FULL;
      end
      OP_OFF: begin
        level_nxt = LVL_OFF;
      end
      default: begin
      end
    endcase

    unique case (level_nxt)
      LVL_FULL: duty = full_tab[bright_r];
      LVL_DIM:  duty = dim_tab[bright_r];
      default:  duty = '0;
    endcase

    out_data_nxt = {2'b00, timeout_r != '0, level_nxt != LVL_OFF, duty, level_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= LVL_FULL;
      last_act_r  <= '0;
      wake_r      <= WAKE_MS;
      timeout_r   <= TIMEOUT_RST;
      bright_r    <= BRIGHT_RST;
      off_lim_r   <= OFF_RST;
      dim_lim_r   <= DIM_RST;
    end else begin
      s1_valid_r <= in_fire || (s1_valid_r && !adv);
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s2_fire) begin
        level_r    <= level_nxt;
        last_act_r <= last_act_nxt;
        wake_r     <= wake_nxt;
      end
      if (cfg_we) begin
        timeout_r <= timeout_nxt;
        bright_r  <= bright_nxt;
        off_lim_r <= off_lim_nxt;
        dim_lim_r <= dim_lim_nxt;
        if (timeout_nxt == '0) begin
          level_r <= LVL_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= op_t'(in_tuser);
      s1_now_r <= in_tdata;
    end
    if (s2_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_off_dark : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[1:0] == LVL_OFF |-> out_data_r[12:2] == '0)
    else $error("off level must give zero duty and unlit");

  a_act_full : assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && s1_op_r == OP_ACT && !cfg_we |=> level_r == LVL_FULL)
    else $error("activity must return the light to full");

  a_manual_full : assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && s1_op_r == OP_TICK && timeout_r == '0 |=> level_r == LVL_FULL)
    else $error("tick with auto dimming disabled must hold full");

  a_lim_order : assert property (@(posedge clk) disable iff (!rst_n)
    timeout_r != '0 |-> dim_lim_r < off_lim_r)
    else $error("dim limit must stay below off limit");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("pending item lost while output stalled");

endmodule

>>> sim/tb_idle_backlight_dimmer_top.sv
module tb_idle_backlight_dimmer_top;
  import ibd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PWM_MAX       = 1023;
  localparam int unsigned DIM_FLOOR     = 40;
  localparam int unsigned WAKE_LATCH_MS = 2000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
  } stamp_beat_t;

  typedef struct packed {
    level_t      level;
    logic [9:0]  duty;
    logic        lit;
    logic        auto_on;
  } backlight_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  idle_backlight_dimmer_top #(
    .PWM_MAX      (PWM_MAX),
    .DIM_FLOOR    (DIM_FLOOR),
    .WAKE_LATCH_MS(WAKE_LATCH_MS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Mirror of the dimmer state, advanced once per accepted input beat.
  level_t      mirror_level   = LVL_FULL;
  logic [31:0] mirror_act_ms  = '0;
  logic [31:0] mirror_wake_ms = 32'(WAKE_LATCH_MS);
  logic [7:0]  mirror_timeout = TIMEOUT_RST;
  logic [7:0]  mirror_bright  = BRIGHT_RST;

  stamp_beat_t stamp_beats[$];
  backlight_t  backlight_due[$];
  stamp_beat_t next_beat;
  backlight_t  want_bl;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_stall = 0;
  int unsigned out_calm = 0;
  logic [31:0] gen_cursor = '0;
  logic [31:0] gen_act_ms = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] off_limit(logic [7:0] minutes);
    return 32'(minutes) * 32'(MS_PER_MIN);
  endfunction

  function automatic logic [31:0] dim_limit(logic [31:0] off_ms);
    logic [31:0] d;
    d = off_ms >> 1;
    if (d < 32'(DIM_MIN_MS)) begin
      d = 32'(DIM_MIN_MS);
    end
    if (d >= off_ms) begin
      d = (off_ms > 32'(DIM_BACKOFF_MS)) ? off_ms - 32'(DIM_BACKOFF_MS) : '0;
    end
    return d;
  endfunction

  function automatic int unsigned bright_duty(logic [7:0] bright);
    int unsigned b;
    b = (bright == 8'd0) ? 1 : int'(bright);
    if (b == 255) begin
      return PWM_MAX;
    end
    return (b * PWM_MAX) / 255;
  endfunction

  function automatic int unsigned dimmed_duty(logic [7:0] bright);
    int unsigned f;
    int unsigned d;
    f = bright_duty(bright);
    d = f / 6;
    if (d < DIM_FLOOR && f > DIM_FLOOR) begin
      d = DIM_FLOOR;
    end
    if (d >= f) begin
      d = (f > 1) ? f / 2 : 1;
    end
    return d;
  endfunction

  task automatic predict_backlight(logic [1:0] op, logic [31:0] now);
    logic [31:0] off_ms;
    logic [31:0] dim_ms;
    logic [31:0] idle_ms;
    backlight_t  bl;
    case (op)
      OP_TICK: begin
        if (mirror_timeout == 8'd0 || now < mirror_wake_ms) begin
          mirror_level = LVL_FULL;
        end else begin
          off_ms  = off_limit(mirror_timeout);
          dim_ms  = dim_limit(off_ms);
          idle_ms = now - mirror_act_ms;
          if (idle_ms >= off_ms) begin
            mirror_level = LVL_OFF;
          end else if (idle_ms >= dim_ms) begin
            mirror_level = LVL_DIM;
          end else begin
            mirror_level = LVL_FULL;
          end
        end
      end
      OP_ACT: begin
        if (mirror_level != LVL_FULL) begin
          mirror_wake_ms = now + 32'(WAKE_LATCH_MS);
        end
        mirror_act_ms = now;
        mirror_level  = LVL_FULL;
      end
      OP_OFF: begin
        mirror_level = LVL_OFF;
      end
      default: begin
      end
    endcase
    bl.level   = mirror_level;
    bl.lit     = (mirror_level != LVL_OFF);
    bl.auto_on = (mirror_timeout != 8'd0);
    case (mirror_level)
      LVL_FULL: bl.duty = 10'(bright_duty(mirror_bright));
      LVL_DIM:  bl.duty = 10'(dimmed_duty(mirror_bright));
      default:  bl.duty = '0;
    endcase
    backlight_due.push_back(bl);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_backlight(in_tuser, in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (stamp_beats.size() != 0) begin
          next_beat = stamp_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= next_beat.op;
          in_tdata  <= next_beat.now;
          if (in_calm != 0) begin
            in_calm <= in_calm - 1;
            in_gap  <= 0;
          end else begin
            if ($urandom_range(0, 24) == 0) begin
              in_calm <= $urandom_range(20, 60);
            end
            in_gap <= pick_gap();
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_calm != 0) begin
        out_calm <= out_calm - 1;
      end else if ($urandom_range(0, 29) == 0) begin
        out_calm <= $urandom_range(20, 60);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (backlight_due.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, 0);
      end else begin
        want_bl = backlight_due.pop_front();
        if (out_tdata[1:0] != want_bl.level) begin
          report_mismatch("level", out_tdata[1:0], want_bl.level);
        end
        if (out_tdata[11:2] != want_bl.duty) begin
          report_mismatch("duty", out_tdata[11:2], want_bl.duty);
        end
        if (out_tdata[12] != want_bl.lit) begin
          report_mismatch("lit", out_tdata[12], want_bl.lit);
        end
        if (out_tdata[13] != want_bl.auto_on) begin
          report_mismatch("auto_on", out_tdata[13], want_bl.auto_on);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout", $realtime);
      $display("idle_backlight_dimmer_top regression: fail");
      $finish;
    end
  end

  task automatic push_beat(logic [1:0] op, logic [31:0] now);
    stamp_beat_t b;
    b.op  = op;
    b.now = now;
    stamp_beats.push_back(b);
    if (op == OP_ACT) begin
      gen_act_ms = now;
    end
    gen_cursor = now;
  endtask

  task automatic settle();
    while (stamp_beats.size() != 0 || in_tvalid || backlight_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [7:0] value);
    logic [31:0] seen;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_TIMEOUT) begin
      mirror_timeout = value;
    end else begin
      mirror_bright = value;
    end
    if (mirror_timeout == 8'd0) begin
      mirror_level = LVL_FULL;
    end
    @(posedge clk);
    cfg_psel <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    seen = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (seen != 32'(value)) begin
      report_mismatch("register readback", seen, value);
    end
  endtask

  // Times wander forward in small and large steps, land within two ms of the
  // idle limits measured from the last activity, and now and then jump anywhere.
  task automatic gen_random(int unsigned count);
    int unsigned made;
    int unsigned r;
    logic [31:0] span;
    logic [31:0] now;
    logic [1:0]  op;
    made = 0;
    while (made < count) begin
      span = (mirror_timeout == 8'd0) ? 32'd600000 : off_limit(mirror_timeout);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        now = gen_cursor + $urandom_range(0, 2500);
      end else if (r < 70) begin
        now = gen_cursor + $urandom_range(0, span + span / 2);
      end else if (r < 85) begin
        now = gen_act_ms + (r[0] ? span : dim_limit(span))
              + 32'($urandom_range(0, 4)) - 32'd2;
      end else if (r < 93) begin
        now = $urandom;
      end else begin
        now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        op = OP_TICK;
      end else if (r < 80) begin
        op = OP_ACT;
      end else if (r < 94) begin
        op = OP_OFF;
      end else begin
        op = OP_UNUSED;
      end
      push_beat(op, now);
      if (op != OP_UNUSED) begin
        made++;
      end
    end
    push_beat(OP_OFF, gen_cursor);
  endtask

  task automatic run_phase(logic [7:0] minutes, logic [7:0] bright, int unsigned count);
    settle();
    cfg_write(REG_TIMEOUT, minutes);
    cfg_write(REG_BRIGHT, bright);
    gen_random(count);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Default setup: ten minutes to off, so dim at five minutes.
    push_beat(OP_TICK, 32'd0);
    push_beat(OP_TICK, 32'd1999);
    push_beat(OP_TICK, 32'd2000);
    push_beat(OP_TICK, 32'd299999);
    push_beat(OP_TICK, 32'd300000);
    push_beat(OP_TICK, 32'd599999);
    push_beat(OP_TICK, 32'd600000);
    push_beat(OP_ACT, 32'd600100);
    push_beat(OP_TICK, 32'd602099);
    push_beat(OP_TICK, 32'd602100);
    push_beat(OP_OFF, 32'd602200);
    push_beat(OP_TICK, 32'd602300);
    push_beat(OP_UNUSED, 32'hFFFF_FFFF);
    push_beat(OP_TICK, 32'd900100);
    push_beat(OP_ACT, 32'hFFFF_FC00);
    push_beat(OP_TICK, 32'hFFFF_FD00);
    push_beat(OP_TICK, 32'hFFFF_FC00 + 32'd300000);
    push_beat(OP_TICK, 32'hFFFF_FC00 + 32'd600000);
    push_beat(OP_UNUSED, 32'd0);
    push_beat(OP_TICK, 32'hFFFF_FFFF);

    run_phase(8'd1, 8'd0, 80);
    run_phase(8'd0, 8'd1, 60);
    run_phase(8'd255, 8'd128, 60);
    run_phase(8'd2, 8'd255, 80);
    run_phase(8'd1, 8'($urandom_range(2, 254)), 80);
    run_phase(8'd3, 8'd6, 80);
    settle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("idle_backlight_dimmer_top regression: pass");
    end else begin
      $display("idle_backlight_dimmer_top regression: fail");
    end
    $finish;
  end

endmodule
